@@ rtl/otrb_pkg.sv @@
// Shared types and constants for the overwriting trace ring buffer.
// No dependencies; imported by every module of the block.
package otrb_pkg;

    localparam int WORD_W      = 64;
    localparam int COUNT_W     = 8;
    localparam int TOTAL_W     = 32;
    localparam int FILL_W      = 5;
    localparam int OP_W        = 2;
    localparam int IN_TDATA_W  = 72;
    localparam int OUT_TDATA_W = 136;
    localparam int OUT_TUSER_W = 2;

    typedef enum logic [OP_W-1:0] {
        OP_PUBLISH = 2'd0,
        OP_READ    = 2'd1,
        OP_STATS   = 2'd2,
        OP_CLEAR   = 2'd3
    } op_t;

    typedef struct packed {
        op_t                op;
        logic [WORD_W-1:0]  data;
        logic [COUNT_W-1:0] max_count;
    } cmd_t;

    typedef struct packed {
        logic               accepted_without_drop;
        logic               entry_valid;
        logic [WORD_W-1:0]  entry_word;
        logic               last_of_run;
        logic [TOTAL_W-1:0] published_total;
        logic [TOTAL_W-1:0] drop_total;
        logic [FILL_W-1:0]  fill_level;
    } result_t;

endpackage

@@ rtl/otrb_front.sv @@
// Front end: accepts input items, decodes the operation and holds them in a
// two-entry command queue. Depends on otrb_pkg.
module otrb_front
    import otrb_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_TDATA_W-1:0] s_tdata,
    input  logic [OP_W-1:0]       s_tuser,
    output logic                  cmd_valid,
    output cmd_t                  cmd,
    input  logic                  cmd_ready
);

    cmd_t       queue_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push, pop;
    cmd_t       incoming;

    assign s_tready  = (cnt_reg != 2'd2);
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd       = queue_reg[rd_ptr_reg];
    assign push      = s_tvalid && s_tready;
    assign pop       = cmd_valid && cmd_ready;

    always_comb begin
        incoming.op        = op_t'(s_tuser);
        incoming.data      = s_tdata[WORD_W-1:0];
        incoming.max_count = s_tdata[WORD_W+COUNT_W-1:WORD_W];
    end

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + 2'd1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            queue_reg[wr_ptr_reg] <= incoming;
        end
    end

endmodule

@@ rtl/otrb_back.sv @@
// Back end: event store, pointers, totals and the read sequencer, with the
// output register. Depends on otrb_pkg.
module otrb_back
    import otrb_pkg::*;
#(
    parameter int CAPACITY   = 16,
    parameter int ENTRY_BITS = 64
) (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    cmd_valid,
    input  cmd_t    cmd,
    output logic    cmd_ready,
    output logic    out_valid,
    output result_t out_item,
    input  logic    out_ready
);

    localparam int PW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP_CNT  = CW'(CAPACITY);
    localparam logic [PW-1:0] LAST_IDX = PW'(CAPACITY - 1);

    typedef enum logic {
        ST_IDLE,
        ST_READ
    } state_t;

    function automatic logic [PW-1:0] ring_next(input logic [PW-1:0] i);
        ring_next = (i == LAST_IDX) ? '0 : i + 1'b1;
    endfunction

    function automatic logic [PW-1:0] ring_prev(input logic [PW-1:0] i);
        ring_prev = (i == '0) ? LAST_IDX : i - 1'b1;
    endfunction

    logic [ENTRY_BITS-1:0] mem [CAPACITY];
    logic [ENTRY_BITS-1:0] rd_data_reg;
    logic [PW-1:0]         rd_addr;
    logic                  mem_we;

    state_t             state_reg, state_next;
    logic [PW-1:0]      wp_reg, wp_next;
    logic [PW-1:0]      idx_reg, idx_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [CW-1:0]      remain_reg, remain_next;
    logic [TOTAL_W-1:0] pub_reg, pub_next;
    logic [TOTAL_W-1:0] drop_reg, drop_next;
    logic               out_valid_reg, out_valid_next;
    result_t            out_reg, out_next;

    logic               out_free, pop, full;
    logic [COUNT_W-1:0] cnt8, take;

    assign out_free  = !out_valid_reg || out_ready;
    assign cmd_ready = (state_reg == ST_IDLE) && out_free;
    assign pop       = cmd_valid && cmd_ready;
    assign full      = (count_reg == CAP_CNT);
    assign cnt8      = COUNT_W'(count_reg);
    assign take      = (cmd.max_count < cnt8) ? cmd.max_count : cnt8;
    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

    always_comb begin
        state_next     = state_reg;
        wp_next        = wp_reg;
        idx_next       = idx_reg;
        count_next     = count_reg;
        remain_next    = remain_reg;
        pub_next       = pub_reg;
        drop_next      = drop_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_next       = out_reg;
        mem_we         = 1'b0;
        rd_addr        = ring_prev(wp_reg);

        case (state_reg)
            ST_IDLE: begin
                if (pop) begin
                    case (cmd.op)
                        OP_PUBLISH: begin
                            mem_we   = 1'b1;
                            wp_next  = ring_next(wp_reg);
                            pub_next = pub_reg + 1'b1;
                            if (full) begin
                                drop_next = drop_reg + 1'b1;
                            end else begin
                                count_next = count_reg + 1'b1;
                            end
                            out_next                       = '0;
                            out_next.accepted_without_drop = !full;
                            out_next.last_of_run           = 1'b1;
                            out_valid_next                 = 1'b1;
                        end
                        OP_READ: begin
                            if (cmd.max_count == '0 || count_reg == '0) begin
                                out_next             = '0;
                                out_next.last_of_run = 1'b1;
                                out_valid_next       = 1'b1;
                            end else begin
                                idx_next    = ring_prev(wp_reg);
                                remain_next = CW'(take);
                                state_next  = ST_READ;
                            end
                        end
                        OP_STATS: begin
                            out_next                 = '0;
                            out_next.published_total = pub_reg;
                            out_next.drop_total      = drop_reg;
                            out_next.fill_level      = cnt8[FILL_W-1:0];
                            out_next.last_of_run     = 1'b1;
                            out_valid_next           = 1'b1;
                        end
                        OP_CLEAR: begin
                            wp_next    = '0;
                            count_next = '0;
                            pub_next   = '0;
                            drop_next  = '0;
                        end
                        default: ;
                    endcase
                end
            end
            ST_READ: begin
                if (out_free) begin
                    rd_addr              = ring_prev(idx_reg);
                    out_next             = '0;
                    out_next.entry_valid = 1'b1;
                    out_next.entry_word  = WORD_W'(rd_data_reg);
                    out_next.last_of_run = (remain_reg == CW'(1));
                    out_valid_next       = 1'b1;
                    idx_next             = ring_prev(idx_reg);
                    remain_next          = remain_reg - 1'b1;
                    if (remain_reg == CW'(1)) begin
                        state_next = ST_IDLE;
                    end
                end else begin
                    rd_addr = idx_reg;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            wp_reg        <= '0;
            idx_reg       <= '0;
            count_reg     <= '0;
            remain_reg    <= '0;
            pub_reg       <= '0;
            drop_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            wp_reg        <= wp_next;
            idx_reg       <= idx_next;
            count_reg     <= count_next;
            remain_reg    <= remain_next;
            pub_reg       <= pub_next;
            drop_reg      <= drop_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[wp_reg] <= cmd.data[ENTRY_BITS-1:0];
        end
        rd_data_reg <= mem[rd_addr];
    end

endmodule

@@ rtl/overwriting_trace_ring_buffer.sv @@
// Top level of the overwriting trace ring buffer: command front end and
// store back end, with stream packing. Depends on otrb_pkg, otrb_front, otrb_back.
//
//   Channel  Direction  tdata                              tuser                 tlast
//   s_       in         entry_data, max_count              operation             -
//   m_       out        entry_word, totals, fill_level     no-drop, entry_valid  last_of_run
//
// Publish, stats and clear are each handled from the idle state; a read starts there
// and then returns its entries one after another, paced by the store's read port.
// Reset empties the log and zeroes both totals; stored words are not cleared.
// A two-entry queue lets input items arrive while the output register stalls.
module overwriting_trace_ring_buffer
    import otrb_pkg::*;
#(
    parameter int CAPACITY   = 16,
    parameter int ENTRY_BITS = 64
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // entry_data[63:0], max_count[71:64]
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    // operation[1:0]
    input  logic [OP_W-1:0]        s_tuser,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // entry_word[63:0], published_total[95:64], drop_total[127:96],
    // fill_level[132:128], zero fill[135:133]
    output logic [OUT_TDATA_W-1:0] m_tdata,
    // accepted_without_drop[0], entry_valid[1]
    output logic [OUT_TUSER_W-1:0] m_tuser,
    output logic                   m_tlast
);

    logic    cmd_valid, cmd_ready;
    cmd_t    cmd;
    result_t res;

    otrb_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_ready (cmd_ready)
    );

    otrb_back #(
        .CAPACITY   (CAPACITY),
        .ENTRY_BITS (ENTRY_BITS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_ready (cmd_ready),
        .out_valid (m_tvalid),
        .out_item  (res),
        .out_ready (m_tready)
    );

    assign m_tdata = {3'b000, res.fill_level, res.drop_total, res.published_total,
                      res.entry_word};
    assign m_tuser = {res.entry_valid, res.accepted_without_drop};
    assign m_tlast = res.last_of_run;

endmodule

@@ verif/overwriting_trace_ring_buffer_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for overwriting_trace_ring_buffer: a directed table, then random
// traffic with random stalls on both streams. Depends on otrb_pkg and the block's RTL.
module overwriting_trace_ring_buffer_tb;
    import otrb_pkg::*;

    localparam int CAP           = 16;
    localparam int RANDOM_ITEMS  = 225;
    localparam int IDLE_LIMIT    = 1000;
    localparam int DRAIN_CYCLES  = 20;

    localparam result_t LAST_ONLY = '{accepted_without_drop: 1'b0, entry_valid: 1'b0,
                                      entry_word: '0, last_of_run: 1'b1,
                                      published_total: '0, drop_total: '0, fill_level: '0};
    localparam result_t PUBLISH_KEPT = '{accepted_without_drop: 1'b1, entry_valid: 1'b0,
                                         entry_word: '0, last_of_run: 1'b1,
                                         published_total: '0, drop_total: '0,
                                         fill_level: '0};

    typedef struct {
        op_t               op;
        logic [WORD_W-1:0] data;
        logic [7:0]        count;
        int unsigned       repeats;
        bit                typed;
        result_t           want;
    } stim_row_t;

    logic                   aclk;
    logic                   aresetn = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic [OP_W-1:0]        s_tuser = OP_PUBLISH;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic [OUT_TUSER_W-1:0] m_tuser;
    logic                   m_tlast;

    logic [WORD_W-1:0]  ring_words [CAP];
    int unsigned        ring_head;
    int unsigned        ring_fill;
    logic [TOTAL_W-1:0] ring_published;
    logic [TOTAL_W-1:0] ring_dropped;
    result_t            ring_results [$];

    int unsigned mismatches;
    int unsigned results_seen;
    int unsigned overwrites_seen;
    int unsigned op_tally [4];
    int unsigned idle_cycles;
    bit          src_burst;
    bit          sink_burst;
    stim_row_t   plan [14];

    overwriting_trace_ring_buffer #(
        .CAPACITY(CAP),
        .ENTRY_BITS(WORD_W)
    ) u_dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .m_tlast(m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic int unsigned pick_wait(inout bit burst);
        if ($urandom_range(0, 15) == 0) begin
            burst = ~burst;
        end
        return burst ? 0 : $urandom_range(0, 12);
    endfunction

    task automatic ring_update(input op_t op, input logic [WORD_W-1:0] word,
                               input logic [7:0] count);
        result_t     r;
        int unsigned n;
        int unsigned idx;
        r = '0;
        r.last_of_run = 1'b1;
        case (op)
            OP_PUBLISH: begin
                r.accepted_without_drop = (ring_fill < CAP);
                if (ring_fill >= CAP) begin
                    ring_fill = CAP - 1;
                    ring_dropped++;
                    overwrites_seen++;
                end
                ring_words[ring_head] = word;
                ring_head = (ring_head + 1) % CAP;
                ring_fill++;
                ring_published++;
                ring_results.push_back(r);
            end
            OP_READ: begin
                if (count == 0 || ring_fill == 0) begin
                    ring_results.push_back(r);
                end else begin
                    n = (count < ring_fill) ? count : ring_fill;
                    idx = ring_head;
                    for (int unsigned i = 0; i < n; i++) begin
                        idx = (idx == 0) ? CAP - 1 : idx - 1;
                        r = '0;
                        r.entry_valid = 1'b1;
                        r.entry_word = ring_words[idx];
                        r.last_of_run = (i + 1 == n);
                        ring_results.push_back(r);
                    end
                end
            end
            OP_STATS: begin
                r.published_total = ring_published;
                r.drop_total = ring_dropped;
                r.fill_level = FILL_W'(ring_fill);
                ring_results.push_back(r);
            end
            OP_CLEAR: begin
                ring_head = 0;
                ring_fill = 0;
                ring_published = '0;
                ring_dropped = '0;
            end
            default: ;
        endcase
    endtask

    task automatic send_item(input op_t op, input logic [WORD_W-1:0] data,
                             input logic [7:0] count, input bit typed, input result_t want);
        int unsigned gap;
        gap = pick_wait(src_burst);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {count, data};
        s_tuser <= op;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        op_tally[op]++;
        ring_update(op, data, count);
        if (typed) begin
            void'(ring_results.pop_back());
            ring_results.push_back(want);
        end
    endtask

    function automatic void check_field(string name, logic [WORD_W-1:0] want,
                                        logic [WORD_W-1:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge aclk) begin : result_check
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (ring_results.size() == 0) begin
                $error("result with no item pending: tdata %0h tuser %0h", m_tdata, m_tuser);
                mismatches++;
            end else begin
                want = ring_results.pop_front();
                check_field("accepted_without_drop", want.accepted_without_drop, m_tuser[0]);
                check_field("entry_valid", want.entry_valid, m_tuser[1]);
                check_field("entry_word", want.entry_word, m_tdata[63:0]);
                check_field("last_of_run", want.last_of_run, m_tlast);
                check_field("published_total", want.published_total, m_tdata[95:64]);
                check_field("drop_total", want.drop_total, m_tdata[127:96]);
                check_field("fill_level", want.fill_level, m_tdata[132:128]);
            end
        end
    end

    initial begin
        int unsigned stall;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            stall = pick_wait(sink_burst);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
        end
    end

    initial begin
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("Timed out with %0d results outstanding.", ring_results.size());
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        op_t               op;
        logic [WORD_W-1:0] data;
        logic [7:0]        count;
        int unsigned       pick;

        ring_head = 0;
        ring_fill = 0;
        ring_published = '0;
        ring_dropped = '0;

        plan[0]  = '{OP_READ,    64'd0,                  8'd5,   1,  1'b1, LAST_ONLY};
        plan[1]  = '{OP_STATS,   64'd0,                  8'd0,   1,  1'b1, LAST_ONLY};
        plan[2]  = '{OP_PUBLISH, 64'd0,                  8'd0,   1,  1'b1, PUBLISH_KEPT};
        plan[3]  = '{OP_PUBLISH, '1,                     8'hFF,  1,  1'b1, PUBLISH_KEPT};
        plan[4]  = '{OP_READ,    64'd0,                  8'd0,   1,  1'b1, LAST_ONLY};
        plan[5]  = '{OP_READ,    64'd0,                  8'hFF,  1,  1'b0, '0};
        plan[6]  = '{OP_PUBLISH, 64'h0123_4567_89AB_CDEF, 8'd0,  14, 1'b0, '0};
        plan[7]  = '{OP_PUBLISH, 64'h8000_0000_0000_0001, 8'd0,  1,  1'b1, LAST_ONLY};
        plan[8]  = '{OP_STATS,   64'd0,                  8'd0,   1,  1'b0, '0};
        plan[9]  = '{OP_READ,    64'd0,                  8'hFF,  1,  1'b0, '0};
        plan[10] = '{OP_READ,    64'd0,                  8'd1,   1,  1'b0, '0};
        plan[11] = '{OP_CLEAR,   '1,                     8'hFF,  1,  1'b0, '0};
        plan[12] = '{OP_READ,    64'd0,                  8'd3,   1,  1'b1, LAST_ONLY};
        plan[13] = '{OP_STATS,   64'd0,                  8'd0,   1,  1'b1, LAST_ONLY};

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (plan[r]) begin
            for (int unsigned k = 0; k < plan[r].repeats; k++) begin
                send_item(plan[r].op, plan[r].data + WORD_W'(k), plan[r].count,
                          plan[r].typed, plan[r].want);
            end
        end

        for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                op = OP_PUBLISH;
            end else if (pick < 78) begin
                op = OP_READ;
            end else if (pick < 96) begin
                op = OP_STATS;
            end else begin
                op = OP_CLEAR;
            end
            data = {$urandom, $urandom};
            case ($urandom_range(0, 9))
                0: data = '0;
                1: data = '1;
                default: ;
            endcase
            if ($urandom_range(0, 1) == 1) begin
                count = 8'($urandom_range(0, 20));
            end else begin
                count = 8'($urandom_range(0, 255));
            end
            send_item(op, data, count, 1'b0, '0);
        end
        s_tvalid <= 1'b0;

        while (ring_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Items: %0d publish, %0d read, %0d stats, %0d clear.",
                 op_tally[OP_PUBLISH], op_tally[OP_READ], op_tally[OP_STATS],
                 op_tally[OP_CLEAR]);
        $display("Checked %0d results; %0d publishes overwrote the oldest entry.",
                 results_seen, overwrites_seen);
        if (mismatches == 0 && ring_results.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
